FILE: rtl/core/chapter_virtual_to_physical_map_unit_defines.svh
// Assertion macros for the chapter virtual-to-physical map unit.
// Included by the RTL files that check their own logic; no other dependency.
`ifndef CHAPTER_VIRTUAL_TO_PHYSICAL_MAP_UNIT_DEFINES_SVH
`define CHAPTER_VIRTUAL_TO_PHYSICAL_MAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CV2P_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CV2P_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define CV2P_ASSERT(lbl, clk, rst, prop)
`define CV2P_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/cv2p_pkg.sv
// Shared types and constants of the chapter virtual-to-physical map unit.
// No dependencies.
`default_nettype none
package cv2p_pkg;
   localparam int ChapterWidth = 64;
   localparam int SlotWidth    = 16;
   localparam int CountWidth   = 17;
   localparam int RemWidth     = 16;
   localparam int ExpireWidth  = 2;
   localparam int CsrIdxWidth  = 2;
   localparam int ReqDataWidth = 3 * ChapterWidth;
   localparam int RspDataWidth = 24;

   localparam logic [CountWidth-1:0] MaxTotal   = 17'd65536;
   localparam logic [CountWidth-1:0] ResetTotal = 17'd1024;
   localparam logic [CountWidth-1:0] ResetDense = 17'd1024;

   localparam logic [CsrIdxWidth-1:0] RegTotal     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegDense     = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegMovedVc   = 2'd2;
   localparam logic [CsrIdxWidth-1:0] RegMovedSlot = 2'd3;

   localparam logic [ExpireWidth-1:0] ExpireNone = 2'd0;
   localparam logic [ExpireWidth-1:0] ExpireOne  = 2'd1;
   localparam logic [ExpireWidth-1:0] ExpireTwo  = 2'd2;

   typedef struct packed {
      logic [CountWidth-1:0]   total;
      logic [CountWidth-1:0]   dense;
      logic [ChapterWidth-1:0] moved_vc;
      logic [SlotWidth-1:0]    moved_slot;
   } cfg_type;

   typedef struct packed {
      logic                   use_mod;
      logic [SlotWidth-1:0]   fixed_slot;
      logic                   has_sparse;
      logic                   query_sparse;
      logic [ExpireWidth-1:0] expire;
   } side_type;
endpackage
`default_nettype wire

FILE: rtl/core/cv2p_front.sv
// Front stages: chapter differences, then classification and modulo operand.
// Depends on cv2p_pkg.
`default_nettype none
module cv2p_front #(
   parameter int CHAPTER_NUMBER_BITS = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cv2p_pkg::cfg_type                    cfg,
   input  wire logic                                 in_valid,
   output logic                                      in_ready,
   input  wire logic [cv2p_pkg::ChapterWidth-1:0]    in_query,
   input  wire logic [cv2p_pkg::ChapterWidth-1:0]    in_oldest,
   input  wire logic [cv2p_pkg::ChapterWidth-1:0]    in_newest,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic [CHAPTER_NUMBER_BITS-1:0]            out_x,
   output cv2p_pkg::side_type                        out_side
);
   import cv2p_pkg::*;

   localparam int Cnb = CHAPTER_NUMBER_BITS;

   logic           a_valid_ff, a_valid_in, a_ready;
   logic [Cnb-1:0] a_q_ff, a_n_ff, a_dup_ff, a_ddn_ff, a_span_ff, a_qd_ff, a_old_ff, a_mvmp_ff;
   logic [Cnb-1:0] a_dup_in, a_ddn_in, a_span_in, a_qd_in, a_old_in, a_mvmp_in;
   logic           a_gt_ff, a_eq_ff, a_nlt_ff, a_gt_in, a_eq_in, a_nlt_in;
   logic [Cnb-1:0] q, o, n, mv, mp;

   logic           b_valid_ff, b_valid_in, b_ready;
   logic [Cnb-1:0] b_x_ff, b_x_in;
   side_type       b_side_ff, b_side_in;

   assign q  = in_query[Cnb-1:0];
   assign o  = in_oldest[Cnb-1:0];
   assign n  = in_newest[Cnb-1:0];
   assign mv = cfg.moved_vc[Cnb-1:0];
   assign mp = Cnb'(cfg.moved_slot);

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      a_gt_in    = q > mv;
      a_eq_in    = q == mv;
      a_dup_in   = q - mv;
      a_ddn_in   = mv - q;
      a_span_in  = n - o + Cnb'(1);
      a_qd_in    = q + Cnb'(cfg.dense);
      a_nlt_in   = 64'(n) < 64'(cfg.total);
      a_old_in   = n - Cnb'(cfg.total);
      a_mvmp_in  = mv + mp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (a_ready && in_valid) begin
         a_q_ff    <= q;
         a_n_ff    <= n;
         a_gt_ff   <= a_gt_in;
         a_eq_ff   <= a_eq_in;
         a_dup_ff  <= a_dup_in;
         a_ddn_ff  <= a_ddn_in;
         a_span_ff <= a_span_in;
         a_qd_ff   <= a_qd_in;
         a_nlt_ff  <= a_nlt_in;
         a_old_ff  <= a_old_in;
         a_mvmp_ff <= a_mvmp_in;
      end
   end

   always_comb begin
      logic moved;
      moved      = cfg.moved_slot != '0;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_x_in     = a_q_ff;
      b_side_in  = '0;
      priority if (!moved) begin
         b_side_in.use_mod = 1'b1;
      end else if (a_gt_ff) begin
         b_x_in = a_dup_ff;
         if (64'(a_dup_ff) > 64'(cfg.moved_slot)) begin
            b_side_in.use_mod = 1'b1;
         end else begin
            b_side_in.fixed_slot = a_dup_ff[SlotWidth-1:0] - 16'd1;
         end
      end else if (a_eq_ff) begin
         b_side_in.fixed_slot = cfg.moved_slot;
      end else if (64'(a_ddn_ff) < 64'(cfg.total)) begin
         b_side_in.fixed_slot = SlotWidth'(cfg.total - 17'(a_ddn_ff));
      end else begin
         b_side_in.fixed_slot = '0;
      end
      b_side_in.has_sparse   = (cfg.dense < cfg.total) && (64'(a_span_ff) > 64'(cfg.dense));
      b_side_in.query_sparse = b_side_in.has_sparse && (a_qd_ff <= a_n_ff);
      priority if (a_nlt_ff) begin
         b_side_in.expire = ExpireNone;
      end else if (moved && a_old_ff == mv) begin
         b_side_in.expire = ExpireTwo;
      end else if (moved && a_old_ff == a_mvmp_ff) begin
         b_side_in.expire = ExpireNone;
      end else begin
         b_side_in.expire = ExpireOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
      if (b_ready && a_valid_ff) begin
         b_x_ff    <= b_x_in;
         b_side_ff <= b_side_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_x     = b_x_ff;
   assign out_side  = b_side_ff;
endmodule
`default_nettype wire

FILE: rtl/core/cv2p_cell.sv
// One remainder cell: folds in one dividend bit and reduces by the slot count.
// Depends on cv2p_pkg and the assertion macro header.
`default_nettype none
`include "chapter_virtual_to_physical_map_unit_defines.svh"
module cv2p_cell #(
   parameter int CHAPTER_NUMBER_BITS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [cv2p_pkg::CountWidth-1:0]    total,
   input  wire logic                               up_valid,
   output logic                                    up_ready,
   input  wire logic [CHAPTER_NUMBER_BITS-1:0]     up_x,
   input  wire logic [cv2p_pkg::RemWidth-1:0]      up_rem,
   input  wire cv2p_pkg::side_type                 up_side,
   output logic                                    dn_valid,
   input  wire logic                               dn_ready,
   output logic [CHAPTER_NUMBER_BITS-1:0]          dn_x,
   output logic [cv2p_pkg::RemWidth-1:0]           dn_rem,
   output cv2p_pkg::side_type                      dn_side
);
   import cv2p_pkg::*;

   localparam int Cnb = CHAPTER_NUMBER_BITS;

   logic                  valid_ff, valid_in;
   logic [Cnb-1:0]        x_ff, x_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   side_type              side_ff;
   logic [CountWidth-1:0] shifted, reduced;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      shifted  = {up_rem, up_x[Cnb-1]};
      reduced  = shifted - total;
      rem_in   = (shifted >= total) ? reduced[RemWidth-1:0] : shifted[RemWidth-1:0];
      x_in     = up_x << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_rem   = rem_ff;
   assign dn_side  = side_ff;

   `CV2P_ASSERT(a_cell_hold_valid, clock, reset, valid_ff && !dn_ready |=> valid_ff)
   `CV2P_ASSERT(a_cell_hold_data, clock, reset,
      valid_ff && !dn_ready |=> $stable(rem_ff) && $stable(side_ff))
   `CV2P_ASSERT(a_cell_rem_below_total, clock, reset, valid_ff |-> CountWidth'(rem_ff) < total)
endmodule
`default_nettype wire

FILE: rtl/core/cv2p_emit.sv
// Output stage: picks the remainder or the remapped slot and holds the word.
// Depends on cv2p_pkg.
`default_nettype none
module cv2p_emit #(
   parameter int SLOT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                up_valid,
   output logic                                     up_ready,
   input  wire logic [cv2p_pkg::RemWidth-1:0]       up_rem,
   input  wire cv2p_pkg::side_type                  up_side,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [cv2p_pkg::RspDataWidth-1:0]        rsp_data
);
   import cv2p_pkg::*;

   localparam logic [SlotWidth-1:0] SlotMask =
      (SLOT_BITS >= SlotWidth) ? {SlotWidth{1'b1}} : SlotWidth'((32'd1 << SLOT_BITS) - 32'd1);

   logic                    valid_ff, valid_in;
   logic [RspDataWidth-1:0] data_ff, data_in;
   logic [SlotWidth-1:0]    slot;

   assign up_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      slot     = (up_side.use_mod ? up_rem : up_side.fixed_slot) & SlotMask;
      data_in  = {4'd0, up_side.expire, up_side.query_sparse, up_side.has_sparse, slot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule
`default_nettype wire

FILE: rtl/core/chapter_virtual_to_physical_map_unit.sv
// Top level of the chapter virtual-to-physical map unit: registers, front, cell row, output.
// Depends on cv2p_pkg, cv2p_front, cv2p_cell, cv2p_emit and the assertion macro header.
//
// channel  direction  handshake                 payload
// req      in         req_tvalid / req_tready   req_tdata: query, oldest, newest chapter
// rsp      out        rsp_tvalid / rsp_tready   rsp_tdata: slot, sparse flags, expire count
// csr      in         csr_we                    csr_index, csr_wdata
//
// One word a cycle while rsp_tready stays high; a word passes the front stages, the row of
// remainder cells, one cell per chapter number bit, and the output stage.
// Reset clears every stage valid and loads the register reset values.
// A full stage holds while the next one is full and held; empty stages collapse, and
// req_tready is high whenever no result is waiting.
`default_nettype none
`include "chapter_virtual_to_physical_map_unit_defines.svh"
module chapter_virtual_to_physical_map_unit #(
   parameter int SLOT_BITS           = 16,
   parameter int CHAPTER_NUMBER_BITS = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [63:0] query chapter, [127:64] tail chapter, [191:128] head chapter
   input  wire logic [cv2p_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [15:0] physical_slot, [16] index_has_sparse, [17] query_is_sparse,
   // [19:18] expire_count, [23:20] zero
   output logic [cv2p_pkg::RspDataWidth-1:0]          rsp_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [cv2p_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire logic [cv2p_pkg::ChapterWidth-1:0]     csr_wdata
);
   import cv2p_pkg::*;

   localparam int Cnb = CHAPTER_NUMBER_BITS;

   cfg_type               cfg_ff, cfg_in;
   logic [CountWidth-1:0] wr_count;

   always_comb begin
      cfg_in   = cfg_ff;
      wr_count = csr_wdata[CountWidth-1:0];
      if (csr_we) begin
         unique case (csr_index)
            RegTotal: begin
               if (wr_count == '0) begin
                  cfg_in.total = 17'd1;
               end else if (wr_count > MaxTotal) begin
                  cfg_in.total = MaxTotal;
               end else begin
                  cfg_in.total = wr_count;
               end
            end
            RegDense: begin
               cfg_in.dense = wr_count;
            end
            RegMovedVc: begin
               cfg_in.moved_vc = csr_wdata;
            end
            RegMovedSlot: begin
               cfg_in.moved_slot = csr_wdata[SlotWidth-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total      <= ResetTotal;
         cfg_ff.dense      <= ResetDense;
         cfg_ff.moved_vc   <= '0;
         cfg_ff.moved_slot <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic                valid_w [0:Cnb];
   logic                ready_w [0:Cnb];
   logic [Cnb-1:0]      x_w     [0:Cnb];
   logic [RemWidth-1:0] rem_w   [0:Cnb];
   side_type            side_w  [0:Cnb];

   assign rem_w[0] = '0;

   cv2p_front #(
      .CHAPTER_NUMBER_BITS(Cnb)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_query  (req_tdata[ChapterWidth-1:0]),
      .in_oldest (req_tdata[2*ChapterWidth-1:ChapterWidth]),
      .in_newest (req_tdata[3*ChapterWidth-1:2*ChapterWidth]),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_x     (x_w[0]),
      .out_side  (side_w[0])
   );

   for (genvar i = 0; i < Cnb; i++) begin : g_cell
      cv2p_cell #(
         .CHAPTER_NUMBER_BITS(Cnb)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .total    (cfg_ff.total),
         .up_valid (valid_w[i]),
         .up_ready (ready_w[i]),
         .up_x     (x_w[i]),
         .up_rem   (rem_w[i]),
         .up_side  (side_w[i]),
         .dn_valid (valid_w[i+1]),
         .dn_ready (ready_w[i+1]),
         .dn_x     (x_w[i+1]),
         .dn_rem   (rem_w[i+1]),
         .dn_side  (side_w[i+1])
      );
   end

   cv2p_emit #(
      .SLOT_BITS(SLOT_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (valid_w[Cnb]),
      .up_ready  (ready_w[Cnb]),
      .up_rem    (rem_w[Cnb]),
      .up_side   (side_w[Cnb]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

   `CV2P_ASSERT(a_ready_when_drained, clock, reset, !rsp_tvalid |-> req_tready)
   `CV2P_ASSERT(a_word_consistent, clock, reset,
      rsp_tvalid |-> (rsp_tdata[19:18] != 2'd3) && !(rsp_tdata[17] && !rsp_tdata[16]))
   `CV2P_ASSERT_ALWAYS(a_quiet_after_reset, clock, !reset && $past(reset) |-> !rsp_tvalid)
endmodule
`default_nettype wire

FILE: bench/tb_chapter_virtual_to_physical_map_unit.sv
// Self-checking bench for the chapter virtual-to-physical map unit: drives chapter words
// through the req stream, checks every rsp word against an in-bench slot predictor.
// Depends on cv2p_pkg and the chapter_virtual_to_physical_map_unit RTL.
`timescale 1ns / 1ps
module tb_chapter_virtual_to_physical_map_unit;
   import cv2p_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_WORDS = 155;
   localparam logic [63:0] ALL_ONES    = '1;

   // highest bits first in the packed word
   typedef struct packed {
      logic [63:0] newest;
      logic [63:0] oldest;
      logic [63:0] query;
   } chapter_query_type;

   typedef struct packed {
      logic [3:0]  pad;
      logic [1:0]  expire_count;
      logic        query_is_sparse;
      logic        index_has_sparse;
      logic [15:0] physical_slot;
   } map_result_type;

   class chapter_map_board;
      bit [16:0]      total_reg;
      bit [16:0]      dense_reg;
      bit [63:0]      moved_vc;
      bit [15:0]      moved_slot;
      map_result_type awaited_maps[$];
      int unsigned    errors;
      int unsigned    checked;

      function new();
         total_reg  = ResetTotal;
         dense_reg  = ResetDense;
         moved_vc   = '0;
         moved_slot = '0;
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [63:0] data);
         case (idx)
            RegTotal:     total_reg  = data[16:0];
            RegDense:     dense_reg  = data[16:0];
            RegMovedVc:   moved_vc   = data;
            RegMovedSlot: moved_slot = data[15:0];
            default: ;
         endcase
      endfunction

      function bit [63:0] eff_total();
         if (total_reg == 0) return 64'd1;
         if (total_reg > MaxTotal) return 64'(MaxTotal);
         return 64'(total_reg);
      endfunction

      function bit [63:0] slot_for(bit [63:0] vc, bit [63:0] tot);
         bit [63:0] gap;
         if (moved_slot == 0) return vc % tot;
         if (vc > moved_vc) begin
            gap = vc - moved_vc;
            if (gap > 64'(moved_slot)) return gap % tot;
            return gap - 64'd1;
         end
         if (vc == moved_vc) return 64'(moved_slot);
         gap = moved_vc - vc;
         if (gap < tot) return tot - gap;
         return 64'd0;
      endfunction

      function bit [1:0] expiry_for(bit [63:0] newest, bit [63:0] tot);
         bit [63:0] retiring;
         if (newest < tot) return ExpireNone;
         if (moved_slot != 0) begin
            retiring = newest - tot;
            if (retiring == moved_vc) return ExpireTwo;
            if (retiring == moved_vc + 64'(moved_slot)) return ExpireNone;
         end
         return ExpireOne;
      endfunction

      function map_result_type map_chapter(chapter_query_type it);
         map_result_type r;
         bit [63:0]      tot;
         bit [63:0]      span;
         bit             sparse_vol;
         tot        = eff_total();
         sparse_vol = 64'(dense_reg) < tot;
         span       = it.newest - it.oldest + 64'd1;
         r = '0;
         r.index_has_sparse = sparse_vol && (span > 64'(dense_reg));
         r.query_is_sparse  = r.index_has_sparse && (it.query + 64'(dense_reg) <= it.newest);
         r.physical_slot    = 16'(slot_for(it.query, tot));
         r.expire_count     = expiry_for(it.newest, tot);
         return r;
      endfunction

      function void note_request(chapter_query_type it);
         awaited_maps.push_back(map_chapter(it));
      endfunction

      function int pending();
         return awaited_maps.size();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(map_result_type got);
         map_result_type want;
         if (awaited_maps.size() == 0) begin
            report($sformatf("unexpected rsp word %h", got));
            return;
         end
         want = awaited_maps.pop_front();
         checked++;
         if (got.physical_slot !== want.physical_slot)
            report($sformatf("physical_slot %h, want %h", got.physical_slot, want.physical_slot));
         if (got.index_has_sparse !== want.index_has_sparse)
            report($sformatf("index_has_sparse %b, want %b",
                             got.index_has_sparse, want.index_has_sparse));
         if (got.query_is_sparse !== want.query_is_sparse)
            report($sformatf("query_is_sparse %b, want %b",
                             got.query_is_sparse, want.query_is_sparse));
         if (got.expire_count !== want.expire_count)
            report($sformatf("expire_count %h, want %h", got.expire_count, want.expire_count));
         if (got.pad !== 4'd0)
            report($sformatf("padding bits %h, want 0", got.pad));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_we;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [ChapterWidth-1:0] csr_wdata;

   chapter_map_board board = new();
   int unsigned      cycle_count;
   int unsigned      words_sent;
   int unsigned      settings_used;
   int unsigned      sender_odds;
   int unsigned      receiver_odds;

   chapter_virtual_to_physical_map_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(map_result_type'(rsp_tdata));
   end

   // stall the result side in bursts
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_odds != 0 && $urandom_range(0, 99) < receiver_odds) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_chapters(input chapter_query_type it);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = it;
      do @(posedge clock); while (!req_tready);
      board.note_request(it);
      words_sent++;
   endtask

   task automatic offer(input logic [63:0] q, input logic [63:0] o, input logic [63:0] n);
      chapter_query_type it;
      it.query  = q;
      it.oldest = o;
      it.newest = n;
      push_chapters(it);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // junk above the register width must be dropped by the block
   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [63:0] value,
                            input int width);
      logic [63:0] mask;
      logic [63:0] word;
      mask = (width >= 64) ? ALL_ONES : ((64'd1 << width) - 64'd1);
      word = value & mask;
      if ($urandom_range(0, 1) == 1) word = word | (rand64() & ~mask);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = word;
      board.write_reg(idx, word);
   endtask

   task automatic set_geometry(input logic [63:0] total, input logic [63:0] dense,
                               input logic [63:0] mv, input logic [63:0] ms);
      drain();
      write_reg(RegTotal, total, CountWidth);
      write_reg(RegDense, dense, CountWidth);
      write_reg(RegMovedVc, mv, ChapterWidth);
      write_reg(RegMovedSlot, ms, SlotWidth);
      @(negedge clock);
      csr_we = 1'b0;
      settings_used++;
   endtask

   // mostly chapters clustered round the moved chapter and the expiry edges
   function automatic chapter_query_type pick_chapters();
      chapter_query_type it;
      logic [63:0]       tot;
      logic [63:0]       dn;
      logic [63:0]       mv;
      logic [63:0]       ms;
      logic [63:0]       anchor;
      logic [63:0]       span;
      int unsigned       t;
      tot = board.eff_total();
      dn  = 64'(board.dense_reg);
      mv  = board.moved_vc;
      ms  = 64'(board.moved_slot);
      t   = tot[31:0];
      if ($urandom_range(0, 9) == 0) begin
         it.query  = rand64();
         it.oldest = rand64();
         it.newest = rand64();
         return it;
      end
      case ($urandom_range(0, 3))
         0, 1:    anchor = mv;
         2:       anchor = rand64();
         default: anchor = 64'($urandom_range(0, 3 * t));
      endcase
      case ($urandom_range(0, 5))
         0:       it.newest = anchor + tot;
         1:       it.newest = anchor + tot + ms;
         2:       it.newest = anchor + 64'($urandom_range(0, 3 * t));
         3:       it.newest = anchor - 64'($urandom_range(0, 2 * t));
         4:       it.newest = 64'($urandom_range(0, 2 * t));
         default: it.newest = anchor + tot + 64'd1;
      endcase
      case ($urandom_range(0, 5))
         0:       span = dn;
         1:       span = dn + 64'd1;
         2:       span = dn - 64'd1;
         3:       span = 64'($urandom_range(1, 2 * t));
         4:       span = 64'd1;
         default: span = rand64();
      endcase
      it.oldest = it.newest - span + 64'd1;
      case ($urandom_range(0, 9))
         0:       it.query = mv;
         1:       it.query = mv - tot;
         2:       it.query = mv - tot + 64'd1;
         3:       it.query = mv + ms;
         4:       it.query = mv + ms + 64'd1;
         5:       it.query = it.newest - dn;
         6:       it.query = it.newest - dn + 64'd1;
         7:       it.query = it.oldest + 64'($urandom_range(0, 2 * t));
         default: it.query = anchor + 64'($urandom_range(0, 4 * t)) - 2 * tot;
      endcase
      return it;
   endfunction

   task automatic run_phase(input logic [63:0] total, input logic [63:0] dense,
                            input logic [63:0] mv, input logic [63:0] ms,
                            input int unsigned odds);
      set_geometry(total, dense, mv, ms);
      sender_odds   = odds;
      receiver_odds = odds;
      repeat (PHASE_WORDS) begin
         if (sender_odds != 0 && $urandom_range(0, 99) < sender_odds)
            pause_sender($urandom_range(1, 12));
         push_chapters(pick_chapters());
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_index     = RegTotal;
      csr_wdata     = '0;
      sender_odds   = 20;
      receiver_odds = 20;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry: plain modulo, index not full, wrap of the span
      offer(64'd0, 64'd0, 64'd0);
      offer(ALL_ONES, ALL_ONES, ALL_ONES);
      offer(64'd1023, 64'd0, 64'd1023);
      offer(64'd1024, 64'd1, 64'd1024);
      offer(rand64(), 64'd0, ALL_ONES);

      // reduced geometry round a moved chapter, sparse edge
      set_geometry(64'd100, 64'd60, 64'd1000, 64'd37);
      offer(64'd1000, 64'd1041, 64'd1100);
      offer(64'd900, 64'd1040, 64'd1137);
      offer(64'd901, 64'd1040, 64'd1101);
      offer(64'd1001, 64'd0, 64'd50);
      offer(64'd1037, 64'd1040, 64'd1100);
      offer(64'd1041, 64'd1040, 64'd1100);
      offer(ALL_ONES, 64'd0, ALL_ONES);

      // zero chapter count, top moved chapter and slot
      set_geometry(64'd0, 64'h1FFFF, ALL_ONES, 64'd65535);
      offer(64'd0, 64'd0, 64'd0);
      offer(ALL_ONES, 64'd1, 64'd0);
      offer(ALL_ONES - 64'd1, ALL_ONES, 64'd5);
      offer(64'd5, 64'd7, 64'd65540);

      // oversized chapter count, moved chapter expiring
      set_geometry(64'h1FFFF, 64'd1, 64'd0, 64'd1);
      offer(64'd5, 64'd0, 64'd65536);
      offer(64'd1, 64'd65537, 64'd65537);
      offer(64'd2, 64'd65538, 64'd65538);
      offer(64'd0, 64'd3, 64'd2);

      run_phase(64'd1024, 64'd1024, 64'd0, 64'd0, 15);
      run_phase(64'd1, 64'd1, rand64(), 64'd0, 40);
      run_phase(64'd1, 64'd1, rand64(), 64'd1, 0);
      run_phase(64'd65536, 64'd65536, ALL_ONES, 64'd0, 15);
      run_phase(64'd65536, 64'd1, rand64(), 64'd65535, 40);
      run_phase(64'd0, 64'd0, rand64(), 64'd5, 15);
      run_phase(64'd65537, 64'h1FFFF, 64'd300, 64'd200, 0);
      run_phase(64'd7, 64'd3, rand64(), 64'd3, 40);
      run_phase(64'd300, 64'd200, rand64(), 64'd299, 15);
      run_phase(64'd16, 64'd1, 64'd0, 64'd15, 40);
      run_phase(64'($urandom_range(1, 65536)), 64'($urandom_range(1, 65536)), rand64(),
                64'($urandom_range(0, 65535)), 15);
      run_phase(64'($urandom_range(1, 4096)), 64'($urandom_range(1, 4096)), rand64(),
                64'($urandom_range(1, 4096)), 0);

      drain();
      repeat (80) @(posedge clock);
      if (board.pending() != 0)
         board.report($sformatf("%0d results never arrived", board.pending()));
      $display("Sent %0d chapter words under %0d register settings, %0d results compared.",
               words_sent, settings_used + 1, board.checked);
      $display("Covered remap edges, count saturation and idle bursts on both streams.");
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
